// ----- rtl/upd_pkg.sv -----
// shared types, character constants and hex helpers of the url percent decoder
package upd_pkg;

  // character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  // queue depths
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 2;

  // capacity after reset
  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  // escape tracking
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_t;

  // work handed from front to back: up to three candidate bytes, then maybe a marker
  typedef struct packed {
    logic [1:0]      nbytes;
    logic            last;
    logic [2:0][7:0] bytes;
  } cmd_t;

  // one result request
  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic        last;
    logic [15:0] length;
    logic        truncated;
  } res_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F)) ||
           ((c >= CH_LO_A) && (c <= CH_LO_F));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c <= CH_UP_F) begin
      v = c - CH_UP_A + HEX_TEN;
    end else begin
      v = c - CH_LO_A + HEX_TEN;
    end
    return v[3:0];
  endfunction

endpackage

// ----- rtl/upd_fifo.sv -----
// small first-in first-out queue built from flops
module upd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/upd_front.sv -----
// front end: tracks escapes and turns each request into a command
module upd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          mode,
  input  logic [7:0]    data,
  output upd_pkg::cmd_t cmd,
  output logic          cmd_push
);
  import upd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       c_hex, c_pct;

  assign c_hex = is_hex(data);
  assign c_pct = (data == CH_PERCENT);

  // next escape state
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (mode) begin
      phase_nxt = PH_IDLE;
      held_nxt  = '0;
    end else begin
      unique case (phase_r)
        PH_PCT: begin
          if (c_hex) begin
            phase_nxt = PH_DIG;
            held_nxt  = data;
          end else begin
            phase_nxt = c_pct ? PH_PCT : PH_IDLE;
          end
        end
        PH_DIG: begin
          held_nxt  = '0;
          phase_nxt = (!c_hex && c_pct) ? PH_PCT : PH_IDLE;
        end
        default: begin
          phase_nxt = c_pct ? PH_PCT : PH_IDLE;
        end
      endcase
    end
  end

  // command contents
  always_comb begin
    cmd        = '0;
    cmd.last   = mode;
    if (mode) begin
      unique case (phase_r)
        PH_PCT: begin
          cmd.bytes[0] = CH_PERCENT;
          cmd.nbytes   = 2'd1;
        end
        PH_DIG: begin
          cmd.bytes[0] = CH_PERCENT;
          cmd.bytes[1] = held_r;
          cmd.nbytes   = 2'd2;
        end
        default: begin
          cmd.nbytes = 2'd0;
        end
      endcase
    end else begin
      unique case (phase_r)
        PH_PCT: begin
          cmd.bytes[0] = CH_PERCENT;
          cmd.bytes[1] = data;
          if (c_hex) begin
            cmd.nbytes = 2'd0;
          end else if (c_pct) begin
            cmd.nbytes = 2'd1;
          end else begin
            cmd.nbytes = 2'd2;
          end
        end
        PH_DIG: begin
          if (c_hex) begin
            cmd.bytes[0] = {hex_val(held_r), hex_val(data)};
            cmd.nbytes   = 2'd1;
          end else begin
            cmd.bytes[0] = CH_PERCENT;
            cmd.bytes[1] = held_r;
            cmd.bytes[2] = data;
            cmd.nbytes   = c_pct ? 2'd2 : 2'd3;
          end
        end
        default: begin
          cmd.bytes[0] = data;
          cmd.nbytes   = c_pct ? 2'd0 : 2'd1;
        end
      endcase
    end
  end

  // only commands with work go into the queue
  assign cmd_push = accept && ((cmd.nbytes != 2'd0) || cmd.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ----- rtl/upd_back.sv -----
// back end: applies the capacity limit and handles one slot per step, issuing at most one result
module upd_back #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [15:0]   capacity,
  input  upd_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  logic          res_full,
  output upd_pkg::res_t res,
  output logic          res_push
);
  import upd_pkg::*;

  localparam int unsigned LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [1:0]             idx_r, idx_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   drop_r, drop_nxt;
  logic                   go, byte_slot, room, final_byte;
  logic [15:0]            limit;
  logic [LW-1:0]          count_ext;
  logic [7:0]             cur_byte;

  assign go         = !cmd_empty && !res_full;
  assign byte_slot  = (idx_r < cmd.nbytes);
  assign final_byte = (idx_r == (cmd.nbytes - 2'd1)) && !cmd.last;
  assign limit      = (capacity == '0) ? '0 : capacity - 16'd1;
  assign count_ext  = LW'(count_r);
  assign room       = (count_ext < LW'(limit)) && (count_r != {COUNT_WIDTH{1'b1}});

  // current candidate byte
  always_comb begin
    unique case (idx_r)
      2'd0:    cur_byte = cmd.bytes[0];
      2'd1:    cur_byte = cmd.bytes[1];
      default: cur_byte = cmd.bytes[2];
    endcase
  end

  // one slot per step: a byte, or the closing marker
  always_comb begin
    idx_nxt   = idx_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    if (go) begin
      if (byte_slot) begin
        if (room) begin
          res_push   = 1'b1;
          res.valid  = 1'b1;
          res.data   = cur_byte;
          count_nxt  = count_r + 1'b1;
        end else begin
          drop_nxt = 1'b1;
        end
        if (final_byte) begin
          cmd_pop = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end else begin
        res_push      = 1'b1;
        res.last      = 1'b1;
        res.length    = count_ext[15:0];
        res.truncated = drop_r;
        count_nxt     = '0;
        drop_nxt      = 1'b0;
        idx_nxt       = '0;
        cmd_pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

// ----- rtl/url_percent_decoder.sv -----
// top level of the streaming url percent decoder
//
//  channel   direction  handshake          payload
//  input     in         in_push / in_full  in_mode, in_byte
//  result    out        out_pop / out_empty out_valid, out_byte, out_last, out_length,
//                                          out_truncated
//  config    in         cfg_we             cfg_capacity
//
// The front takes one request per cycle while the command queue (4 deep) has room.
// The back works through a request's candidate bytes (kept or dropped), then its marker,
// and issues at most one result per cycle into a 2-deep result queue while it has room.
// It sustains one request per cycle while results drain and each is one byte or marker.
// Synchronous active-low reset; capacity resets to 65535; no clearing pass.
// A stalled result side fills the result queue, then the command queue, then raises in_full.
module url_percent_decoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_capacity,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_mode,
  input  logic [7:0]  in_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [15:0] out_length,
  output logic        out_truncated
);
  import upd_pkg::*;

  logic [15:0] capacity_r;
  logic        in_accept;
  cmd_t        front_cmd, back_cmd;
  logic        cmd_push, cmd_pop, cmd_full, cmd_empty;
  res_t        back_res, head_res;
  logic        res_push, res_full;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_capacity;
    end
  end

  assign in_accept = in_push && !in_full;
  assign in_full   = cmd_full;

  // front end
  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .mode     (in_mode),
    .data     (in_byte),
    .cmd      (front_cmd),
    .cmd_push (cmd_push)
  );

  // command queue between front and back
  upd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (front_cmd),
    .pop     (cmd_pop),
    .rd_data (back_cmd),
    .full    (cmd_full),
    .empty   (cmd_empty)
  );

  // back end
  upd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (capacity_r),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res       (back_res),
    .res_push  (res_push)
  );

  // result queue
  upd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (back_res),
    .pop     (out_pop),
    .rd_data (head_res),
    .full    (res_full),
    .empty   (out_empty)
  );

  assign out_valid     = head_res.valid;
  assign out_byte      = head_res.data;
  assign out_last      = head_res.last;
  assign out_length    = head_res.length;
  assign out_truncated = head_res.truncated;

  // checks
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into a full queue");

  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty && !res_full)
    else $error("command retired without a step");

  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last) |-> (!out_valid && out_byte == 8'd0))
    else $error("marker carries a data byte");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> in_accept)
    else $error("command queued without an input request");

endmodule
